// ----- design/rational_arith_unit_macros.svh -----
// Assertion macros shared by the rational arithmetic unit modules.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rau_pkg.sv -----
// Shared constants, types and helpers for the rational arithmetic unit.
// No dependencies; imported by the controller, the datapath and the top level.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int IN_W          = 16;
    localparam int ACT_W         = 2;
    localparam int RES_NUM_W     = 33;
    localparam int RES_DEN_W     = 31;

    // Product, signed numerator and magnitude widths.
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int NW = PW + 1;
    localparam int MW = NW;
    localparam int KW = $clog2(MW);
    localparam int CW = $clog2(MW);
    localparam int XW = (OPERAND_WIDTH > IN_W) ? OPERAND_WIDTH : IN_W;

    localparam int IN_TDATA_W  = ((ACT_W + 4 * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 2'd3;

    // Product / accumulate step selectors.
    localparam logic [1:0] SEL_P0 = 2'd0;
    localparam logic [1:0] SEL_P1 = 2'd1;
    localparam logic [1:0] SEL_P2 = 2'd2;

    typedef logic signed [OPERAND_WIDTH-1:0] t_op;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_en;
        logic [1:0] acc_sel;
        logic       prep;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
        logic num_zero;
        logic gcd_done;
        logic out_free;
    } t_dp_sts;

    // Take an input field as an OPERAND_WIDTH-bit two's complement value.
    function automatic t_op to_op(input logic [IN_W-1:0] f);
        logic [XW-1:0] z;
        z = XW'(f);
        return t_op'(z[OPERAND_WIDTH-1:0]);
    endfunction

endpackage

// ----- design/rau_ctrl.sv -----
// Sequencing state machine of the rational arithmetic unit.
// Depends on rau_pkg and rational_arith_unit_macros.svh; drives rau_dp commands.
`include "rational_arith_unit_macros.svh"

module rau_ctrl
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_PREP = 6'b000100,
        ST_GCD  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                // Form one product per cycle, fold the previous one in behind it.
                o_cmd.mul_en  = (r_cnt < CW'(3));
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.acc_en  = (r_cnt != '0);
                o_cmd.acc_sel = r_cnt[1:0] - 2'd1;
                n_cnt         = r_cnt + CW'(1);
                if (r_cnt == CW'(3)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.err || i_sts.num_zero) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = CW'(MW - 1);
                    n_state        = ST_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `RAU_ASSERT_NEXT(a_prep_exit, r_state == ST_PREP, r_state == ST_GCD || r_state == ST_OUT, "prep must lead to gcd or output")
    `RAU_ASSERT_NEXT(a_div_end, r_state == ST_DIV && r_cnt == '0, r_state == ST_OUT, "divide must end in output after last step")
    `RAU_ASSERT_NEXT(a_out_exit, r_state == ST_OUT && i_sts.out_free, r_state == ST_IDLE, "output load must return to idle")

endmodule

// ----- design/rau_dp.sv -----
// Datapath of the rational arithmetic unit: products, binary GCD, two dividers.
// Depends on rau_pkg and rational_arith_unit_macros.svh; driven by rau_ctrl.
`include "rational_arith_unit_macros.svh"

module rau_dp
    import rau_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic [ACT_W-1:0]            i_action,
    input  logic [IN_W-1:0]             i_a_num,
    input  logic [IN_W-1:0]             i_a_den,
    input  logic [IN_W-1:0]             i_b_num,
    input  logic [IN_W-1:0]             i_b_den,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [RES_NUM_W-1:0] o_res_num,
    output logic [RES_DEN_W-1:0]        o_res_den,
    output logic                        o_status
);

    logic [ACT_W-1:0]      r_act;
    t_op                   r_an, r_ad, r_bn, r_bd;
    logic                  r_err;
    logic signed [PW-1:0]  r_prod;
    logic signed [NW-1:0]  r_num;
    logic signed [PW-1:0]  r_den;
    logic                  r_neg;
    logic [MW-1:0]         r_u, r_v;
    logic [KW-1:0]         r_k;
    logic [MW-1:0]         r_g;
    logic [MW-1:0]         r_qn, r_qd;
    logic [MW-1:0]         r_rem_n, r_rem_d;
    logic                  r_valid;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]  r_res_den;
    logic                  r_status;

    t_op                  w_x, w_y;
    logic signed [PW-1:0] w_prod;
    logic signed [NW-1:0] w_prod_ext;
    logic [MW-1:0]        w_num_mag, w_den_mag;
    logic [MW:0]          w_trial_n, w_trial_d;
    logic                 w_ge_n, w_ge_d;
    logic [MW:0]          w_signed_q;
    logic                 w_out_free;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (i_cmd.mul_sel)
            SEL_P0: begin
                w_x = r_an;
                w_y = (r_act == ACT_MUL) ? r_bn : r_bd;
            end
            SEL_P1: begin
                w_x = r_bn;
                w_y = r_ad;
            end
            default: begin
                w_x = r_ad;
                w_y = (r_act == ACT_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    assign w_prod     = w_x * w_y;
    assign w_prod_ext = NW'(r_prod);
    assign w_num_mag  = r_num[NW-1] ? MW'(unsigned'(-r_num)) : MW'(unsigned'(r_num));
    assign w_den_mag  = r_den[PW-1] ? MW'(unsigned'(-r_den)) : MW'(unsigned'(r_den));

    assign w_trial_n = {r_rem_n, r_qn[MW-1]};
    assign w_trial_d = {r_rem_d, r_qd[MW-1]};
    assign w_ge_n    = (w_trial_n >= {1'b0, r_g});
    assign w_ge_d    = (w_trial_d >= {1'b0, r_g});
    assign w_signed_q = r_neg ? (-{1'b0, r_qn}) : {1'b0, r_qn};

    assign w_out_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_an  <= to_op(i_a_num);
            r_ad  <= to_op(i_a_den);
            r_bn  <= to_op(i_b_num);
            r_bd  <= to_op(i_b_den);
            r_err <= (to_op(i_a_den) == '0) || (to_op(i_b_den) == '0)
                     || ((i_action == ACT_DIV) && (to_op(i_b_num) == '0));
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_en) begin
            unique case (i_cmd.acc_sel)
                SEL_P0: r_num <= w_prod_ext;
                SEL_P1: begin
                    // Only add and subtract have a second numerator term.
                    if (r_act == ACT_ADD) begin
                        r_num <= r_num + w_prod_ext;
                    end else if (r_act == ACT_SUB) begin
                        r_num <= r_num - w_prod_ext;
                    end
                end
                default: r_den <= r_prod;
            endcase
        end
        if (i_cmd.prep) begin
            r_neg <= r_num[NW-1] ^ r_den[PW-1];
            r_u   <= w_num_mag;
            r_v   <= w_den_mag;
            r_qn  <= w_num_mag;
            r_qd  <= w_den_mag;
            r_k   <= '0;
        end
        if (i_cmd.gcd_step) begin
            priority if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g     <= r_u << r_k;
            r_rem_n <= '0;
            r_rem_d <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_n <= w_ge_n ? MW'(w_trial_n - {1'b0, r_g}) : w_trial_n[MW-1:0];
            r_rem_d <= w_ge_d ? MW'(w_trial_d - {1'b0, r_g}) : w_trial_d[MW-1:0];
            r_qn    <= {r_qn[MW-2:0], w_ge_n};
            r_qd    <= {r_qd[MW-2:0], w_ge_d};
        end
        if (i_cmd.out_load) begin
            priority if (r_err) begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_status  <= 1'b1;
            end else if (r_num == '0) begin
                r_res_num <= '0;
                r_res_den <= RES_DEN_W'(1);
                r_status  <= 1'b0;
            end else begin
                r_res_num <= RES_NUM_W'(signed'(w_signed_q));
                r_res_den <= RES_DEN_W'(r_qd);
                r_status  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_sts.err      = r_err;
    assign o_sts.num_zero = (r_num == '0);
    assign o_sts.gcd_done = (r_u == r_v);
    assign o_sts.out_free = w_out_free;

    assign o_valid   = r_valid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

    `RAU_ASSERT_NOW(a_gcd_nonzero, i_cmd.gcd_step, r_u != '0 && r_v != '0, "gcd operand reached zero")
    `RAU_ASSERT_NOW(a_rem_bound, i_cmd.div_step, r_rem_n < r_g && r_rem_d < r_g, "divider remainder not below divisor")
    `RAU_ASSERT_NEXT(a_load_valid, i_cmd.out_load, r_valid, "result lost after output load")
    `RAU_ASSERT_NOW(a_den_ok, r_valid && !r_status, r_res_den != '0, "zero denominator on a good result")

endmodule

// ----- design/rational_arith_unit.sv -----
// Rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions and return the result in lowest terms with a positive denominator.
//
// Input channel s_axis: one request per item; action and four 16-bit operands.
// Output channel m_axis: one result per request; numerator, denominator, and
// an error flag on m_axis_tuser (zero denominator or division by zero, 0/0).
// A zero numerator gives 0/1.
// Steps: products formed on one shared multiplier, a setup step, the
// binary GCD (one shift or subtract step per cycle), forming the GCD,
// 33 steps of two restoring dividers, and the output load.
// Error and zero-numerator items skip the GCD and the dividers.
// One item is worked on at a time; the next request is taken as soon as the
// result sits in the output register, even if it has not been taken yet.
// If the receiver stalls, the result holds in the output register and a
// finished next item waits in the controller until that register frees.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops
// any result not yet taken.
// Depends on rau_pkg, rau_ctrl and rau_dp.
module rational_arith_unit
    import rau_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // action[1:0], a_num[17:2], a_den[33:18], b_num[49:34], b_den[65:50], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // res_num[32:0], res_den[63:33]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[0]
    output logic                   m_axis_tuser
);

    t_dp_cmd                     w_cmd;
    t_dp_sts                     w_sts;
    logic                        w_in_ready;
    logic signed [RES_NUM_W-1:0] w_res_num;
    logic [RES_DEN_W-1:0]        w_res_den;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    rau_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_action  (s_axis_tdata[ACT_W-1:0]),
        .i_a_num   (s_axis_tdata[ACT_W + IN_W - 1 : ACT_W]),
        .i_a_den   (s_axis_tdata[ACT_W + 2*IN_W - 1 : ACT_W + IN_W]),
        .i_b_num   (s_axis_tdata[ACT_W + 3*IN_W - 1 : ACT_W + 2*IN_W]),
        .i_b_den   (s_axis_tdata[ACT_W + 4*IN_W - 1 : ACT_W + 3*IN_W]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res_num (w_res_num),
        .o_res_den (w_res_den),
        .o_status  (m_axis_tuser)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tdata  = OUT_TDATA_W'({w_res_den, w_res_num});

endmodule
